// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the trmb RTL.
// Needs i_clk and i_rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/trmb_pkg.sv =====
// Shared constants, register codes and the controller command struct.
// No dependencies.
`timescale 1ns / 1ps

package trmb_pkg;

    localparam int SIZE_DEF   = 5;
    localparam int VAL_W      = 20;
    localparam int BOUND_W    = 24;
    localparam int CITY_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [VAL_W-1:0]   INF_COST  = 20'd999999;
    localparam logic [BOUND_W-1:0] BOUND_MAX = 24'hFFFFFF;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_ENABLE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FROM_CITY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TO_CITY     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PARENT_COST = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_COST   = 3'd4;

    // controller to datapath commands
    typedef struct packed {
        logic load_wr;   // store the incoming word
        logic clr_sum;   // new run: clear reduction total
        logic copy_v;    // copy/mask/row-min element
        logic rows_v;    // row-subtract/column-min element
        logic out_load;  // load output register
        logic out_last;  // final word of the run
    } t_ctl;

endpackage

// ===== rtl/trmb_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module trmb_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 25
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/trmb_ctrl.sv =====
// Sequencer: load count, pass counters and output handshake.
// Depends on trmb_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module trmb_ctrl #(
    parameter int SIZE = trmb_pkg::SIZE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_last_entry,
    input  logic                          i_out_ready,
    output logic                          o_in_ready,
    output logic                          o_out_valid,
    output trmb_pkg::t_ctl                o_ctl,
    output logic [$clog2(SIZE*SIZE)-1:0]  o_wr_idx,
    output logic [$clog2(SIZE*SIZE)-1:0]  o_rd_idx,
    output logic [$clog2(SIZE*SIZE)-1:0]  o_prc_idx,
    output logic [$clog2(SIZE)-1:0]       o_prc_row,
    output logic [$clog2(SIZE)-1:0]       o_prc_col,
    output logic [$clog2(SIZE)-1:0]       o_out_col
);

    import trmb_pkg::*;

    localparam int CELLS = SIZE * SIZE;
    localparam int IW    = $clog2(CELLS);
    localparam int LW    = $clog2(SIZE);
    localparam logic [IW-1:0] LAST_IDX  = IW'(CELLS - 1);
    localparam logic [LW-1:0] LAST_LINE = LW'(SIZE - 1);

    typedef enum logic [5:0] {
        S_LOAD  = 6'b000001,
        S_COPY  = 6'b000010,
        S_ROWS  = 6'b000100,
        S_ORD   = 6'b001000,
        S_OLD   = 6'b010000,
        S_OSHOW = 6'b100000
    } t_state;

    t_state          r_state, n_state;
    logic [IW-1:0]   r_load_cnt, n_load_cnt;
    logic [IW-1:0]   r_iss_idx, n_iss_idx;
    logic [LW-1:0]   r_iss_row, n_iss_row;
    logic [LW-1:0]   r_iss_col, n_iss_col;
    logic            r_iss_busy, n_iss_busy;
    logic            r_prc_v, n_prc_v;
    logic [IW-1:0]   r_prc_idx;
    logic [LW-1:0]   r_prc_row;
    logic [LW-1:0]   r_prc_col;

    logic            w_in_acc;
    logic            w_out_acc;
    logic            w_pass_end;
    logic [IW-1:0]   w_nx_idx;
    logic [LW-1:0]   w_nx_row;
    logic [LW-1:0]   w_nx_col;

    assign o_in_ready  = (r_state == S_LOAD);
    assign o_out_valid = (r_state == S_OSHOW);
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign w_out_acc   = o_out_valid && i_out_ready;
    assign w_pass_end  = r_prc_v && (r_prc_idx == LAST_IDX);

    // row-major walk
    assign w_nx_idx = r_iss_idx + 1'b1;
    assign w_nx_col = (r_iss_col == LAST_LINE) ? '0 : r_iss_col + 1'b1;
    assign w_nx_row = (r_iss_col == LAST_LINE) ? r_iss_row + 1'b1 : r_iss_row;

    always_comb begin
        n_state    = r_state;
        n_load_cnt = r_load_cnt;
        n_iss_idx  = r_iss_idx;
        n_iss_row  = r_iss_row;
        n_iss_col  = r_iss_col;
        n_iss_busy = r_iss_busy;
        n_prc_v    = 1'b0;
        case (r_state)
            S_LOAD: begin
                if (w_in_acc) begin
                    if (i_last_entry) begin
                        n_load_cnt = '0;
                        n_state    = S_COPY;
                        n_iss_idx  = '0;
                        n_iss_row  = '0;
                        n_iss_col  = '0;
                        n_iss_busy = 1'b1;
                    end else begin
                        n_load_cnt = (r_load_cnt == LAST_IDX) ? '0 : r_load_cnt + 1'b1;
                    end
                end
            end
            S_COPY, S_ROWS: begin
                if (r_iss_busy) begin
                    n_prc_v   = 1'b1;
                    n_iss_idx = w_nx_idx;
                    n_iss_row = w_nx_row;
                    n_iss_col = w_nx_col;
                    if (r_iss_idx == LAST_IDX) begin
                        n_iss_busy = 1'b0;
                    end
                end
                if (w_pass_end) begin
                    n_iss_idx  = '0;
                    n_iss_row  = '0;
                    n_iss_col  = '0;
                    n_iss_busy = (r_state == S_COPY);
                    n_state    = (r_state == S_COPY) ? S_ROWS : S_ORD;
                end
            end
            S_ORD: begin
                n_state = S_OLD;
            end
            S_OLD: begin
                n_state = S_OSHOW;
            end
            S_OSHOW: begin
                if (w_out_acc) begin
                    if (r_iss_idx == LAST_IDX) begin
                        n_state = S_LOAD;
                    end else begin
                        n_iss_idx = w_nx_idx;
                        n_iss_row = w_nx_row;
                        n_iss_col = w_nx_col;
                        n_state   = S_ORD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_LOAD;
            r_load_cnt <= '0;
            r_iss_idx  <= '0;
            r_iss_row  <= '0;
            r_iss_col  <= '0;
            r_iss_busy <= 1'b0;
            r_prc_v    <= 1'b0;
            r_prc_idx  <= '0;
            r_prc_row  <= '0;
            r_prc_col  <= '0;
        end else begin
            r_state    <= n_state;
            r_load_cnt <= n_load_cnt;
            r_iss_idx  <= n_iss_idx;
            r_iss_row  <= n_iss_row;
            r_iss_col  <= n_iss_col;
            r_iss_busy <= n_iss_busy;
            r_prc_v    <= n_prc_v;
            r_prc_idx  <= r_iss_idx;
            r_prc_row  <= r_iss_row;
            r_prc_col  <= r_iss_col;
        end
    end

    always_comb begin
        o_ctl          = '0;
        o_ctl.load_wr  = w_in_acc;
        o_ctl.clr_sum  = w_in_acc && i_last_entry;
        o_ctl.copy_v   = r_prc_v && (r_state == S_COPY);
        o_ctl.rows_v   = r_prc_v && (r_state == S_ROWS);
        o_ctl.out_load = (r_state == S_OLD);
        o_ctl.out_last = (r_state == S_OLD) && (r_iss_idx == LAST_IDX);
    end

    assign o_wr_idx  = r_load_cnt;
    assign o_rd_idx  = r_iss_idx;
    assign o_prc_idx = r_prc_idx;
    assign o_prc_row = r_prc_row;
    assign o_prc_col = r_prc_col;
    assign o_out_col = r_iss_col;

    `ASSERT_ALWAYS(a_no_load_during_output, !(o_in_ready && o_out_valid), "ready and valid overlap")
    `ASSERT_NEXT(a_last_starts_copy, w_in_acc && i_last_entry, (r_state == S_COPY) && r_iss_busy, "last word did not start copy pass")
    `ASSERT_IMPL(a_prc_in_pass, r_prc_v, (r_state == S_COPY) || (r_state == S_ROWS), "element processed outside a pass")
    `ASSERT_NEXT(a_final_frees_input, w_out_acc && (r_iss_idx == LAST_IDX), o_in_ready && (r_load_cnt == '0), "run end did not return to load")

endmodule

// ===== rtl/trmb_dpath.sv =====
// Datapath: matrix store, working matrix, line minima, reduction total, output word.
// Depends on trmb_pkg, trmb_ram and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module trmb_dpath #(
    parameter int SIZE = trmb_pkg::SIZE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  trmb_pkg::t_ctl                      i_ctl,
    input  logic [$clog2(SIZE*SIZE)-1:0]        i_wr_idx,
    input  logic [$clog2(SIZE*SIZE)-1:0]        i_rd_idx,
    input  logic [$clog2(SIZE*SIZE)-1:0]        i_prc_idx,
    input  logic [$clog2(SIZE)-1:0]             i_prc_row,
    input  logic [$clog2(SIZE)-1:0]             i_prc_col,
    input  logic [$clog2(SIZE)-1:0]             i_out_col,
    input  logic [trmb_pkg::VAL_W-1:0]          i_entry_value,
    input  logic                                i_mask_enable,
    input  logic [trmb_pkg::CITY_W-1:0]         i_from_city,
    input  logic [trmb_pkg::CITY_W-1:0]         i_to_city,
    input  logic [trmb_pkg::BOUND_W-1:0]        i_parent_cost,
    input  logic [trmb_pkg::VAL_W-1:0]          i_edge_cost,
    output logic [trmb_pkg::VAL_W-1:0]          o_entry_out,
    output logic [trmb_pkg::BOUND_W-1:0]        o_bound_cost,
    output logic                                o_final_entry
);

    import trmb_pkg::*;

    localparam int CELLS = SIZE * SIZE;
    localparam int LW    = $clog2(SIZE);
    localparam int TW    = BOUND_W + 2;
    localparam logic [LW-1:0] LAST_LINE = LW'(SIZE - 1);

    // reduction taken from a line minimum: none for an all-infinite line
    function automatic logic [VAL_W-1:0] red_of(input logic [VAL_W-1:0] m);
        return (m == INF_COST) ? '0 : m;
    endfunction

    logic [VAL_W-1:0]   w_st_q, w_wk_q;
    logic               w_wk_we;
    logic [VAL_W-1:0]   w_wk_wdata;

    logic [VAL_W-1:0]   r_run_min;
    logic [VAL_W-1:0]   r_row_red [SIZE];
    logic [VAL_W-1:0]   r_col_val [SIZE];   // column minimum, then its reduction
    logic [BOUND_W-1:0] r_sum;
    logic [VAL_W-1:0]   r_out_entry;
    logic [BOUND_W-1:0] r_out_bound;
    logic               r_out_final;

    logic [VAL_W-1:0]   w_clamp, w_copy_val, w_row_min;
    logic               w_hit;
    logic [VAL_W-1:0]   w_rows_val, w_col_min, w_out_val;
    logic [VAL_W-1:0]   w_sum_add;
    logic [TW-1:0]      w_total;
    logic [BOUND_W-1:0] w_bound;

    trmb_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_store (
        .i_clk   (i_clk),
        .i_we    (i_ctl.load_wr),
        .i_waddr (i_wr_idx),
        .i_wdata (i_entry_value),
        .i_raddr (i_rd_idx),
        .o_rdata (w_st_q)
    );

    trmb_ram #(.WIDTH(VAL_W), .DEPTH(CELLS)) u_work (
        .i_clk   (i_clk),
        .i_we    (w_wk_we),
        .i_waddr (i_prc_idx),
        .i_wdata (w_wk_wdata),
        .i_raddr (i_rd_idx),
        .o_rdata (w_wk_q)
    );

    // copy pass: clamp, mask, running row minimum
    assign w_clamp = (w_st_q > INF_COST) ? INF_COST : w_st_q;
    assign w_hit   = (i_mask_enable && (4'(i_from_city) == 4'(i_prc_row)))
                  || (i_mask_enable && (4'(i_to_city) == 4'(i_prc_col)))
                  || ((4'(i_to_city) == 4'(i_prc_row)) && (i_prc_col == '0));
    assign w_copy_val = w_hit ? INF_COST : w_clamp;
    assign w_row_min  = (i_prc_col == '0) ? w_copy_val
                      : ((w_copy_val < r_run_min) ? w_copy_val : r_run_min);

    // row pass: subtract row reduction, running column minimum
    assign w_rows_val = (w_wk_q == INF_COST) ? INF_COST : w_wk_q - r_row_red[i_prc_row];
    assign w_col_min  = (i_prc_row == '0) ? w_rows_val
                      : ((w_rows_val < r_col_val[i_prc_col]) ? w_rows_val
                                                             : r_col_val[i_prc_col]);

    assign w_wk_we    = i_ctl.copy_v || i_ctl.rows_v;
    assign w_wk_wdata = i_ctl.copy_v ? w_copy_val : w_rows_val;

    always_comb begin
        w_sum_add = '0;
        if (i_ctl.copy_v && (i_prc_col == LAST_LINE)) begin
            w_sum_add = red_of(w_row_min);
        end else if (i_ctl.rows_v && (i_prc_row == LAST_LINE)) begin
            w_sum_add = red_of(w_col_min);
        end
    end

    // output: subtract column reduction; bound saturates at 24 bits
    assign w_out_val = (w_wk_q == INF_COST) ? INF_COST : w_wk_q - r_col_val[i_out_col];
    assign w_total   = TW'(i_parent_cost) + TW'(i_edge_cost) + TW'(r_sum);
    assign w_bound   = (w_total > TW'(BOUND_MAX)) ? BOUND_MAX : w_total[BOUND_W-1:0];

    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_sum) begin
            r_sum <= '0;
        end else begin
            r_sum <= r_sum + BOUND_W'(w_sum_add);
        end
        if (i_ctl.copy_v) begin
            r_run_min <= w_row_min;
            if (i_prc_col == LAST_LINE) begin
                r_row_red[i_prc_row] <= red_of(w_row_min);
            end
        end
        if (i_ctl.rows_v) begin
            r_col_val[i_prc_col] <= (i_prc_row == LAST_LINE) ? red_of(w_col_min) : w_col_min;
        end
        if (i_ctl.out_load) begin
            r_out_entry <= w_out_val;
            r_out_bound <= i_ctl.out_last ? w_bound : '0;
            r_out_final <= i_ctl.out_last;
        end
    end

    assign o_entry_out   = r_out_entry;
    assign o_bound_cost  = r_out_bound;
    assign o_final_entry = r_out_final;

    `ASSERT_ALWAYS(a_one_command, $onehot0({i_ctl.load_wr, i_ctl.copy_v, i_ctl.rows_v, i_ctl.out_load}), "datapath commands overlap")

endmodule

// ===== rtl/tsp_reduced_matrix_bound.sv =====
// Top level: reduced cost matrix child bound for TSP branch and bound.
// Depends on trmb_pkg, trmb_ctrl, trmb_dpath (and through it trmb_ram).
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+-------------------------------------
//  input     | i_in_valid / o_in_ready    | i_entry_value, i_last_entry
//  output    | o_out_valid / i_out_ready  | o_entry_out, o_bound_cost, o_final_entry
//  config    | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// Loading takes one word per cycle between runs, written straight into the matrix
// store RAM. A word with last set starts a run: a copy/mask pass, then a row pass,
// each one RAM read and one write per cycle. Output words then go out one at a time,
// each through a RAM read, a result register and a handshake that waits while
// i_out_ready is held low; input is not taken during a run.
// Synchronous active-low reset; no clearing pass, the store is undefined until written.
`timescale 1ns / 1ps

module tsp_reduced_matrix_bound #(
    parameter int SIZE = trmb_pkg::SIZE_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // matrix words in
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic [trmb_pkg::VAL_W-1:0]          i_entry_value,
    input  logic                                i_last_entry,
    // reduced words out
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [trmb_pkg::VAL_W-1:0]          o_entry_out,
    output logic [trmb_pkg::BOUND_W-1:0]        o_bound_cost,
    output logic                                o_final_entry,
    // configuration writes
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [trmb_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [trmb_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    import trmb_pkg::*;

    localparam int IW = $clog2(SIZE * SIZE);
    localparam int LW = $clog2(SIZE);

    // configuration registers
    logic                r_mask_enable;
    logic [CITY_W-1:0]   r_from_city;
    logic [CITY_W-1:0]   r_to_city;
    logic [BOUND_W-1:0]  r_parent_cost;
    logic [VAL_W-1:0]    r_edge_cost;

    t_ctl                w_ctl;
    logic [IW-1:0]       w_wr_idx, w_rd_idx, w_prc_idx;
    logic [LW-1:0]       w_prc_row, w_prc_col, w_out_col;

    // writes are always taken; unknown indexes are dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_enable <= 1'b0;
            r_from_city   <= '0;
            r_to_city     <= '0;
            r_parent_cost <= '0;
            r_edge_cost   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_MASK_ENABLE: r_mask_enable <= i_cfg_data[0];
                CFG_FROM_CITY:   r_from_city   <= i_cfg_data[CITY_W-1:0];
                CFG_TO_CITY:     r_to_city     <= i_cfg_data[CITY_W-1:0];
                CFG_PARENT_COST: r_parent_cost <= i_cfg_data[BOUND_W-1:0];
                CFG_EDGE_COST:   r_edge_cost   <= i_cfg_data[VAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // sequencing: load count, pass counters, output handshake
    trmb_ctrl #(.SIZE(SIZE)) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_last_entry (i_last_entry),
        .i_out_ready  (i_out_ready),
        .o_in_ready   (o_in_ready),
        .o_out_valid  (o_out_valid),
        .o_ctl        (w_ctl),
        .o_wr_idx     (w_wr_idx),
        .o_rd_idx     (w_rd_idx),
        .o_prc_idx    (w_prc_idx),
        .o_prc_row    (w_prc_row),
        .o_prc_col    (w_prc_col),
        .o_out_col    (w_out_col)
    );

    // storage and arithmetic
    trmb_dpath #(.SIZE(SIZE)) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_wr_idx      (w_wr_idx),
        .i_rd_idx      (w_rd_idx),
        .i_prc_idx     (w_prc_idx),
        .i_prc_row     (w_prc_row),
        .i_prc_col     (w_prc_col),
        .i_out_col     (w_out_col),
        .i_entry_value (i_entry_value),
        .i_mask_enable (r_mask_enable),
        .i_from_city   (r_from_city),
        .i_to_city     (r_to_city),
        .i_parent_cost (r_parent_cost),
        .i_edge_cost   (r_edge_cost),
        .o_entry_out   (o_entry_out),
        .o_bound_cost  (o_bound_cost),
        .o_final_entry (o_final_entry)
    );

endmodule

// ===== tb/tb_tsp_reduced_matrix_bound.sv =====
// Self-checking bench for tsp_reduced_matrix_bound: loads cost matrices, predicts the
// reduced matrix and child bound per run, and checks every output word in order.
// Depends on trmb_pkg and the tsp_reduced_matrix_bound RTL.
`timescale 1ns / 1ps

module tb_tsp_reduced_matrix_bound;
    import trmb_pkg::*;

    localparam int N     = SIZE_DEF;
    localparam int CELLS = N * N;

    localparam int SETTLE_CYCLES = 12;    // block goes idle soon after its final word
    localparam int HOLD_CYCLES   = 300;   // long output stall in the free-running phase
    localparam int STALL_LIMIT   = 3000;  // cycles without any handshake
    localparam int PHASE_WORDS   = 16;    // minimum random input words per pacing phase

    // Opening matrix: all-zero and all-ones words, values above infinity,
    // an all-infinite row and a mix of small costs.
    localparam logic [VAL_W-1:0] OPENING [CELLS] = '{
        20'd0,      20'd999999, 20'd1048575, 20'd1000000, 20'd7,
        20'd999999, 20'd999999, 20'd999999,  20'd999999,  20'd999999,
        20'd12,     20'd30,     20'd999998,  20'd15,      20'd12,
        20'd524288, 20'd999999, 20'd3,       20'd262143,  20'd40,
        20'd5,      20'd0,      20'd999999,  20'd8,       20'd1
    };

    typedef struct packed {
        logic [VAL_W-1:0]   entry;
        logic [BOUND_W-1:0] bound;
        logic               fin;
    } t_reduced_word;

    // Who idles: sender 37% / receiver 80%, then swapped, then nobody.
    typedef enum logic [1:0] {PH_RECV_SLOW, PH_SEND_SLOW, PH_FREE} t_pace;

    // ------------------------------------------------------------------
    // Scoreboard: mirrors the matrix store and registers, queues the
    // reduced words that each run should produce.
    // ------------------------------------------------------------------
    class reduction_checker;
        logic [VAL_W-1:0]   store [CELLS];
        logic [VAL_W-1:0]   work  [CELLS];
        int unsigned        fill;
        logic               mask_on;
        logic [CITY_W-1:0]  from_row;
        logic [CITY_W-1:0]  to_col;
        logic [BOUND_W-1:0] parent_bound;
        logic [VAL_W-1:0]   edge_len;
        t_reduced_word      expected_words [$];
        int                 failures;

        function new();
            fill         = 0;
            mask_on      = 1'b0;
            from_row     = '0;
            to_col       = '0;
            parent_bound = '0;
            edge_len     = '0;
            failures     = 0;
            foreach (store[k]) store[k] = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MASK_ENABLE: mask_on      = data[0];
                CFG_FROM_CITY:   from_row     = data[CITY_W-1:0];
                CFG_TO_CITY:     to_col       = data[CITY_W-1:0];
                CFG_PARENT_COST: parent_bound = data[BOUND_W-1:0];
                CFG_EDGE_COST:   edge_len     = data[VAL_W-1:0];
                default: ;
            endcase
        endfunction

        // Take the finite positive minimum off one row or column of work.
        function int unsigned reduce_line(int unsigned start, int unsigned stride);
            logic [VAL_W-1:0] least;
            int unsigned      k;
            least = INF_COST;
            for (k = 0; k < N; k++)
                if (work[start + k * stride] < least) least = work[start + k * stride];
            if (least == INF_COST || least == '0) return 0;
            for (k = 0; k < N; k++)
                if (work[start + k * stride] != INF_COST)
                    work[start + k * stride] = work[start + k * stride] - least;
            return least;
        endfunction

        function void note_word(logic [VAL_W-1:0] value, logic last);
            int unsigned   k;
            int unsigned   taken;
            logic [63:0]   total;
            t_reduced_word word;
            if (fill >= CELLS) fill = 0;
            store[fill] = value;
            fill = (fill + 1) % CELLS;
            if (!last) return;

            // anything above infinity reads as infinity
            for (k = 0; k < CELLS; k++)
                work[k] = (store[k] > INF_COST) ? INF_COST : store[k];
            // city indexes past the matrix edge mask nothing
            if (mask_on) begin
                for (k = 0; k < N; k++) begin
                    if (from_row < N) work[from_row * N + k] = INF_COST;
                    if (to_col < N)   work[k * N + to_col]   = INF_COST;
                end
            end
            if (to_col < N) work[to_col * N] = INF_COST;

            taken = 0;
            for (k = 0; k < N; k++) taken += reduce_line(k * N, 1);
            for (k = 0; k < N; k++) taken += reduce_line(k, N);

            total = 64'(parent_bound) + 64'(edge_len) + 64'(taken);
            if (total > 64'(BOUND_MAX)) total = 64'(BOUND_MAX);

            for (k = 0; k < CELLS; k++) begin
                word.entry = work[k];
                word.bound = (k == CELLS - 1) ? total[BOUND_W-1:0] : '0;
                word.fin   = (k == CELLS - 1);
                expected_words = {expected_words, word};
            end
            fill = 0;
        endfunction

        function void flag(string field, logic [BOUND_W-1:0] want, logic [BOUND_W-1:0] got);
            failures++;
            $display("%0t: %s expected %0d got %0d", $time, field, want, got);
        endfunction

        function void check_word(logic [VAL_W-1:0] entry, logic [BOUND_W-1:0] bound,
                                 logic fin);
            t_reduced_word want;
            if (expected_words.size() == 0) begin
                failures++;
                $display("%0t: word expected none got entry %0d bound %0d final %0b",
                         $time, entry, bound, fin);
                return;
            end
            want = expected_words.pop_front();
            if (entry !== want.entry)
                flag("entry_out", BOUND_W'(want.entry), BOUND_W'(entry));
            if (bound !== want.bound)
                flag("bound_cost", want.bound, bound);
            if (fin !== want.fin)
                flag("final_entry", BOUND_W'(want.fin), BOUND_W'(fin));
        endfunction
    endclass

    // ------------------------------------------------------------------
    // Signals and DUT
    // ------------------------------------------------------------------
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_ready;
    logic [VAL_W-1:0]      i_entry_value = '0;
    logic                  i_last_entry  = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready   = 1'b0;
    logic [VAL_W-1:0]      o_entry_out;
    logic [BOUND_W-1:0]    o_bound_cost;
    logic                  o_final_entry;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;

    reduction_checker sb;
    t_pace            pace          = PH_RECV_SLOW;
    int               send_gap_pct  = 37;
    int               recv_gap_pct  = 80;
    int               hold_left     = 0;
    logic             hold_used     = 1'b0;
    int               idle_cycles   = 0;

    tsp_reduced_matrix_bound i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_entry_value (i_entry_value),
        .i_last_entry  (i_last_entry),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_entry_out   (o_entry_out),
        .o_bound_cost  (o_bound_cost),
        .o_final_entry (o_final_entry),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // Output side: check the accepted word, then pick next cycle's ready.
    // On entering the free-running phase ready is held low for a long
    // stretch so the block backs up and stops taking input words.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_word(o_entry_out, o_bound_cost, o_final_entry);
        if (pace == PH_FREE && !hold_used) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_gap_pct);
        end
    end

    // Watchdog: any handshake restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("[tsp_reduced_matrix_bound] ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    // One matrix word; valid is left high on return so back-to-back words
    // need no second assignment in the same step.
    task automatic send_word(input logic [VAL_W-1:0] value, input logic last);
        while ($urandom_range(99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_entry_value <= value;
        i_last_entry  <= last;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(value, last);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
    endtask

    // Only called once the block is drained.
    task automatic load_settings(input logic mask, input logic [CITY_W-1:0] from_c,
                                 input logic [CITY_W-1:0] to_c,
                                 input logic [BOUND_W-1:0] parent,
                                 input logic [VAL_W-1:0] edge_c);
        put_reg(CFG_MASK_ENABLE, CFG_DATA_W'(mask));
        put_reg(CFG_FROM_CITY,   CFG_DATA_W'(from_c));
        put_reg(CFG_TO_CITY,     CFG_DATA_W'(to_c));
        put_reg(CFG_PARENT_COST, CFG_DATA_W'(parent));
        put_reg(CFG_EDGE_COST,   CFG_DATA_W'(edge_c));
        i_cfg_valid <= 1'b0;
    endtask

    // Sender pauses until every expected word is back, then a short settle.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.expected_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly small costs so reductions bite; zeros, infinities and
    // over-range words mixed in.
    function automatic logic [VAL_W-1:0] pick_cost();
        int r;
        r = $urandom_range(99);
        if (r < 8)  return INF_COST;
        if (r < 13) return VAL_W'($urandom_range(1048575, 1000000));
        if (r < 23) return '0;
        if (r < 70) return VAL_W'($urandom_range(60, 1));
        return VAL_W'($urandom_range(999998));
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        int                 p;
        int                 k;
        int                 len;
        int                 sent;
        int                 run_no;
        int                 r;
        logic               first_long;
        logic [BOUND_W-1:0] parent;
        logic [VAL_W-1:0]   edge_c;

        sb = new();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: full opening matrix with registers at their minimum,
        // so (0,0) goes infinite and every store position gets written.
        load_settings(1'b0, '0, '0, '0, '0);
        for (k = 0; k < CELLS; k++) send_word(OPENING[k], k == CELLS - 1);
        wait_drained();

        // Early last word, cities beyond the matrix edge, bound saturates.
        load_settings(1'b1, 3'd7, 3'd7, BOUND_MAX, INF_COST);
        send_word(20'd3, 1'b1);

        // Random matrices over three pacing phases; the first one
        // overruns the store so the write pointer wraps.
        first_long = 1'b1;
        for (p = 0; p < 3; p++) begin
            wait_drained();
            pace = t_pace'(p);
            case (pace)
                PH_RECV_SLOW: begin send_gap_pct = 37; recv_gap_pct = 80; end
                PH_SEND_SLOW: begin send_gap_pct = 80; recv_gap_pct = 37; end
                default:      begin send_gap_pct = 0;  recv_gap_pct = 0;  end
            endcase
            sent   = 0;
            run_no = 0;
            // the free phase always gets a second matrix to queue up
            while (sent < PHASE_WORDS || (pace == PH_FREE && run_no < 2)) begin
                // In the free phase the second matrix follows straight on so
                // it queues up behind the long output hold.
                if (run_no == 0 || ($urandom_range(1) == 1
                        && !(pace == PH_FREE && run_no == 1))) begin
                    if (run_no != 0) wait_drained();
                    r = $urandom_range(99);
                    if (r < 10)      parent = BOUND_MAX;
                    else if (r < 20) parent = '0;
                    else if (r < 45) parent = BOUND_MAX - BOUND_W'($urandom_range(3000000));
                    else             parent = BOUND_W'($urandom_range(24'hFFFFFF));
                    r = $urandom_range(99);
                    if (r < 10)      edge_c = '0;
                    else if (r < 20) edge_c = INF_COST;
                    else if (r < 25) edge_c = VAL_W'($urandom_range(1048575, 1000000));
                    else             edge_c = VAL_W'($urandom_range(999999));
                    load_settings(1'($urandom_range(1)), CITY_W'($urandom_range(7)),
                                  CITY_W'($urandom_range(7)), parent, edge_c);
                end
                r = $urandom_range(99);
                if (first_long) begin
                    len        = $urandom_range(30, CELLS + 1);
                    first_long = 1'b0;
                end else if (r < 60) begin
                    len = CELLS;
                end else if (r < 85) begin
                    len = $urandom_range(8, 1);       // partial update of the store
                end else begin
                    len = $urandom_range(30, CELLS + 1);
                end
                for (k = 0; k < len; k++) send_word(pick_cost(), k == len - 1);
                sent += len;
                run_no++;
            end
        end

        wait_drained();
        if (sb.failures == 0 && sb.expected_words.size() == 0) begin
            $display("[tsp_reduced_matrix_bound] OK");
        end else begin
            $display("[tsp_reduced_matrix_bound] ERROR");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/trmb_pkg.sv
rtl/trmb_ram.sv
rtl/trmb_ctrl.sv
rtl/trmb_dpath.sv
rtl/tsp_reduced_matrix_bound.sv
tb/tb_tsp_reduced_matrix_bound.sv
